/* rtl/bmmr_pkg.sv */
`timescale 1ns / 1ps
package bmmr_pkg;

  // Field widths.
  localparam int COORD_W   = 12;
  localparam int CEN_W     = 16;
  localparam int FRAC_W    = 4;
  localparam int OFF_W     = 13;
  localparam int MAG_W     = 12;
  localparam int SQ_W      = 24;
  localparam int DIST_W    = 26;
  localparam int RAD_W     = 13;
  localparam int DIR_W     = 9;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_START = 2'd2;

  localparam logic [DIST_W-1:0] MIN_START_RESET = 26'd100000;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Angle scan.
  localparam int ANG_W = 7;
  localparam int TAB_N = 91;
  localparam int TAB_W = 41;
  localparam logic [ANG_W-1:0] ANG_FIRST = 7'd1;
  localparam logic [ANG_W-1:0] ANG_LAST  = 7'd89;
  localparam logic [ANG_W-1:0] ANG_DIAG  = 7'd45;
  localparam logic [DIR_W-1:0] HALF_TURN = 9'd180;

  // One finished shape, handed from the front to the back.
  typedef struct packed {
    logic [DIST_W-1:0]       max_dist;
    logic [DIST_W-1:0]       min_dist;
    logic signed [OFF_W-1:0] far_x;
    logic signed [OFF_W-1:0] far_y;
    logic signed [OFF_W-1:0] near_x;
    logic signed [OFF_W-1:0] near_y;
  } rec_t;

  // Sine and cosine of whole degrees, built at elaboration from a Taylor
  // series in 64-bit fixed point with 60 fraction bits and kept with 40 fraction bits.
  localparam logic [63:0] PI_Q     = 64'h3243F6A8885A308D;
  localparam logic [63:0] ANG_STEP = PI_Q / 180;
  localparam logic [63:0] ONE_Q    = 64'h1000000000000000;
  localparam int unsigned SIN_DEN [15] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
                                           506, 600, 702, 812, 930};
  localparam int unsigned COS_DEN [15] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
                                           462, 552, 650, 756, 870};

  typedef logic [TAB_W-1:0] tab_t [TAB_N];

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic tab_t build_tab(input logic want_cos);
    tab_t t;
    logic [63:0] x, x2, st, ss, ct, cs;
    for (int k = 0; k < TAB_N; k++) begin
      x  = ANG_STEP * 64'(k);
      x2 = mul_q(x, x);
      st = x;
      ss = x;
      ct = ONE_Q;
      cs = ONE_Q;
      for (int n = 1; n <= 15; n++) begin
        st = mul_q(st, x2) / 64'(SIN_DEN[n-1]);
        ct = mul_q(ct, x2) / 64'(COS_DEN[n-1]);
        if ((n % 2) == 1) begin
          ss = ss - st;
          cs = cs - ct;
        end else begin
          ss = ss + st;
          cs = cs + ct;
        end
      end
      t[k] = want_cos ? cs[60:20] : ss[60:20];
    end
    return t;
  endfunction

  localparam tab_t SIN_TAB = build_tab(1'b0);
  localparam tab_t COS_TAB = build_tab(1'b1);

endpackage

/* rtl/border_max_min_radius_unit.sv */
`timescale 1ns / 1ps
// Points are taken at one per cycle while in_stall_o is low. For each shape, two
// 13-step square roots run beside two scans of angles 1 to 89 of the 91-entry
// sine/cosine tables, one per direction. Up to four finished shapes wait in the
// queue. Reset clears control state and sets the minimum start to 100000.
module border_max_min_radius_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bmmr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bmmr_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bmmr_pkg::COORD_W-1:0]        point_x_i,
  input  logic [bmmr_pkg::COORD_W-1:0]        point_y_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bmmr_pkg::RAD_W-1:0]          max_radius_o,
  output logic [bmmr_pkg::RAD_W-1:0]          min_radius_o,
  output logic signed [bmmr_pkg::DIR_W-1:0]   max_direction_o,
  output logic signed [bmmr_pkg::DIR_W-1:0]   min_direction_o
);
  import bmmr_pkg::*;

  logic [CEN_W-1:0]   centre_x_q, centre_y_q;
  logic [DIST_W-1:0]  min_start_q;
  logic               push, pop, q_valid;
  rec_t               push_rec, pop_rec;
  logic [FIFO_CW-1:0] q_count;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q  <= '0;
      centre_y_q  <= '0;
      min_start_q <= MIN_START_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CENTRE_X:  centre_x_q  <= cfg_wdata_i[CEN_W-1:0];
        REG_CENTRE_Y:  centre_y_q  <= cfg_wdata_i[CEN_W-1:0];
        REG_MIN_START: min_start_q <= cfg_wdata_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  bmmr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .last_point_i (last_point_i),
    .centre_x_i   (centre_x_q),
    .centre_y_i   (centre_y_q),
    .min_start_i  (min_start_q),
    .q_count_i    (q_count),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  bmmr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (pop_rec),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  bmmr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .rec_i           (pop_rec),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .max_radius_o    (max_radius_o),
    .min_radius_o    (min_radius_o),
    .max_direction_o (max_direction_o),
    .min_direction_o (min_direction_o)
  );

endmodule

/* rtl/bmmr_front.sv */
`timescale 1ns / 1ps
module bmmr_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bmmr_pkg::COORD_W-1:0]    point_x_i,
  input  logic [bmmr_pkg::COORD_W-1:0]    point_y_i,
  input  logic                            last_point_i,
  input  logic [bmmr_pkg::CEN_W-1:0]      centre_x_i,
  input  logic [bmmr_pkg::CEN_W-1:0]      centre_y_i,
  input  logic [bmmr_pkg::DIST_W-1:0]     min_start_i,
  input  logic [bmmr_pkg::FIFO_CW-1:0]    q_count_i,
  output logic                            push_o,
  output bmmr_pkg::rec_t                  rec_o
);
  import bmmr_pkg::*;

  // Offset from the centroid, truncated toward zero.
  function automatic logic signed [OFF_W-1:0] offset_of(input logic [COORD_W-1:0] p,
                                                        input logic [CEN_W-1:0] c);
    logic signed [CEN_W:0] d;
    logic [CEN_W:0]        mag;
    logic [OFF_W-1:0]      q;
    d   = $signed({1'b0, p, {FRAC_W{1'b0}}}) - $signed({1'b0, c});
    mag = d[CEN_W] ? $unsigned(-d) : $unsigned(d);
    q   = mag[CEN_W:FRAC_W];
    return d[CEN_W] ? $signed(-q) : $signed(q);
  endfunction

  logic                     accept;
  logic                     s1_v_q, s1_last_q;
  logic signed [OFF_W-1:0]  s1_x_q, s1_y_q;
  logic                     s2_v_q, s2_last_q;
  logic signed [OFF_W-1:0]  s2_x_q, s2_y_q;
  logic [SQ_W-1:0]          s2_sqx_q, s2_sqy_q;
  logic signed [2*OFF_W-1:0] sqx, sqy;
  logic [FIFO_CW-1:0]       pending;

  logic                     first_q;
  logic [DIST_W-1:0]        best_max_q, best_min_q;
  logic signed [OFF_W-1:0]  far_x_q, far_y_q, near_x_q, near_y_q;

  logic [DIST_W-1:0]        pt_dist, base_max, base_min, new_max, new_min;
  logic signed [OFF_W-1:0]  new_far_x, new_far_y, new_near_x, new_near_y;
  logic                     upd_max, upd_min;

  // Hold off when queued shapes plus shape ends in flight fill every queue slot.
  assign pending    = q_count_i + FIFO_CW'(s1_v_q && s1_last_q) + FIFO_CW'(s2_v_q && s2_last_q);
  assign in_stall_o = (pending >= FIFO_CW'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign sqx = s1_x_q * s1_x_q;
  assign sqy = s1_y_q * s1_y_q;

  // Offset and square stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= last_point_i;
    s1_x_q    <= offset_of(point_x_i, centre_x_i);
    s1_y_q    <= offset_of(point_y_i, centre_y_i);
    s2_last_q <= s1_last_q;
    s2_x_q    <= s1_x_q;
    s2_y_q    <= s1_y_q;
    s2_sqx_q  <= sqx[SQ_W-1:0];
    s2_sqy_q  <= sqy[SQ_W-1:0];
  end

  // Running extremes; the first point seeds both positions.
  always_comb begin
    pt_dist  = DIST_W'(s2_sqx_q) + DIST_W'(s2_sqy_q);
    base_max = first_q ? '0 : best_max_q;
    base_min = first_q ? min_start_i : best_min_q;
    upd_max  = pt_dist > base_max;
    upd_min  = pt_dist < base_min;
    new_max  = upd_max ? pt_dist : base_max;
    new_min  = upd_min ? pt_dist : base_min;
    new_far_x  = (upd_max || first_q) ? s2_x_q : far_x_q;
    new_far_y  = (upd_max || first_q) ? s2_y_q : far_y_q;
    new_near_x = (upd_min || first_q) ? s2_x_q : near_x_q;
    new_near_y = (upd_min || first_q) ? s2_y_q : near_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      best_max_q <= '0;
      best_min_q <= MIN_START_RESET;
      far_x_q    <= '0;
      far_y_q    <= '0;
      near_x_q   <= '0;
      near_y_q   <= '0;
    end else if (s2_v_q) begin
      first_q    <= s2_last_q;
      best_max_q <= new_max;
      best_min_q <= new_min;
      far_x_q    <= new_far_x;
      far_y_q    <= new_far_y;
      near_x_q   <= new_near_x;
      near_y_q   <= new_near_y;
    end
  end

  assign push_o        = s2_v_q && s2_last_q;
  assign rec_o.max_dist = new_max;
  assign rec_o.min_dist = new_min;
  assign rec_o.far_x    = new_far_x;
  assign rec_o.far_y    = new_far_y;
  assign rec_o.near_x   = new_near_x;
  assign rec_o.near_y   = new_near_y;

  a_first_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> first_q)
    else $error("shape end did not rearm the first point");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (q_count_i < FIFO_CW'(FIFO_DEPTH)))
    else $error("shape end reached a full queue");

endmodule

/* rtl/bmmr_fifo.sv */
`timescale 1ns / 1ps
module bmmr_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  bmmr_pkg::rec_t               rec_i,
  input  logic                         pop_i,
  output bmmr_pkg::rec_t               rec_o,
  output logic                         valid_o,
  output logic [bmmr_pkg::FIFO_CW-1:0] count_o
);
  import bmmr_pkg::*;

  rec_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
    end
  end

  assign rec_o   = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && (count_q == FIFO_CW'(FIFO_DEPTH))))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && (count_q == '0)))
    else $error("queue read while empty");

endmodule

/* rtl/bmmr_back.sv */
`timescale 1ns / 1ps
module bmmr_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  bmmr_pkg::rec_t                      rec_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bmmr_pkg::RAD_W-1:0]          max_radius_o,
  output logic [bmmr_pkg::RAD_W-1:0]          min_radius_o,
  output logic signed [bmmr_pkg::DIR_W-1:0]   max_direction_o,
  output logic signed [bmmr_pkg::DIR_W-1:0]   min_direction_o
);
  import bmmr_pkg::*;

  localparam int REM_W    = 15;
  localparam int SQ_CNT_W = 4;
  localparam int PROD_W   = MAG_W + TAB_W;
  localparam logic [SQ_CNT_W-1:0] SQ_STEPS = 4'd13;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0] v;
    logic [REM_W-1:0]  rem;
    logic [RAD_W-1:0]  root;
  } sq_t;

  // One digit of the restoring square root.
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t              r;
    logic [REM_W-1:0] rem_t, trial;
    rem_t = {s.rem[REM_W-3:0], s.v[DIST_W-1:DIST_W-2]};
    trial = {s.root, 2'b01};
    r.v   = {s.v[DIST_W-3:0], 2'b00};
    if (rem_t >= trial) begin
      r.rem  = rem_t - trial;
      r.root = {s.root[RAD_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_t;
      r.root = {s.root[RAD_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] abs_of(input logic signed [OFF_W-1:0] o);
    logic [OFF_W-1:0] m;
    m = o[OFF_W-1] ? $unsigned(-o) : $unsigned(o);
    return m[MAG_W-1:0];
  endfunction

  // Fold the first-quadrant angle into the full circle.
  function automatic logic signed [DIR_W-1:0] dir_of(input logic signed [OFF_W-1:0] ox,
                                                     input logic signed [OFF_W-1:0] oy,
                                                     input logic [ANG_W-1:0] f);
    logic [MAG_W-1:0] ax, ay;
    logic [ANG_W-1:0] fe;
    logic [DIR_W-1:0] d;
    logic             exact;
    ax    = abs_of(ox);
    ay    = abs_of(oy);
    exact = (ay == '0) || (ay == ax);
    fe    = (ay == ax) ? ANG_DIAG : ((ay == '0) ? '0 : f);
    if (!ox[OFF_W-1]) begin
      d = DIR_W'(fe);
    end else if (exact) begin
      d = HALF_TURN - DIR_W'(fe);
    end else begin
      d = HALF_TURN - DIR_W'(1) - DIR_W'(fe);
    end
    if (ox == '0) begin
      return '0;
    end
    return oy[OFF_W-1] ? $signed(-d) : $signed(d);
  endfunction

  logic [1:0]              state_q;
  rec_t                    rec_q;
  sq_t                     smax_q, smin_q;
  logic [SQ_CNT_W-1:0]     sq_cnt_q;
  logic                    sqrt_done;
  logic                    pass_q, issue_q, pv_q, dir_done_q;
  logic [ANG_W-1:0]        k_q, pk_q, f_q, f_new;
  logic [PROD_W-1:0]       pc_q, ps_q;
  logic signed [OFF_W-1:0] cur_x, cur_y;
  logic [MAG_W-1:0]        cur_ax, cur_ay;
  logic signed [DIR_W-1:0] dir_val, dir_far_q, dir_near_q;
  logic                    out_free, load_out;

  logic                    out_valid_q;
  logic [RAD_W-1:0]        max_radius_q, min_radius_q;
  logic signed [DIR_W-1:0] max_dir_q, min_dir_q;

  assign sqrt_done = (sq_cnt_q == SQ_STEPS);
  assign cur_x     = pass_q ? rec_q.near_x : rec_q.far_x;
  assign cur_y     = pass_q ? rec_q.near_y : rec_q.far_y;
  assign cur_ax    = abs_of(cur_x);
  assign cur_ay    = abs_of(cur_y);
  assign f_new     = (pv_q && (pc_q > ps_q)) ? pk_q : f_q;
  assign dir_val   = dir_of(cur_x, cur_y, f_new);
  assign pop_o     = (state_q == B_IDLE) && q_valid_i;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == B_DONE) && out_free;

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      issue_q    <= 1'b0;
      pv_q       <= 1'b0;
      dir_done_q <= 1'b0;
      pass_q     <= 1'b0;
      sq_cnt_q   <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            state_q    <= B_RUN;
            issue_q    <= 1'b1;
            pv_q       <= 1'b0;
            dir_done_q <= 1'b0;
            pass_q     <= 1'b0;
            sq_cnt_q   <= '0;
          end
        end
        B_RUN: begin
          if (!sqrt_done) begin
            sq_cnt_q <= sq_cnt_q + 1'b1;
          end
          pv_q <= issue_q;
          if (issue_q && (k_q == ANG_LAST)) begin
            issue_q <= 1'b0;
          end
          if (pv_q && (pk_q == ANG_LAST)) begin
            if (!pass_q) begin
              pass_q  <= 1'b1;
              issue_q <= 1'b1;
            end else begin
              dir_done_q <= 1'b1;
            end
          end
          if (sqrt_done && dir_done_q) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // Square roots and the degree scan.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q  <= rec_i;
      smax_q <= '{v: rec_i.max_dist, rem: '0, root: '0};
      smin_q <= '{v: rec_i.min_dist, rem: '0, root: '0};
      k_q    <= ANG_FIRST;
      f_q    <= '0;
    end else if (state_q == B_RUN) begin
      if (!sqrt_done) begin
        smax_q <= sqrt_step(smax_q);
        smin_q <= sqrt_step(smin_q);
      end
      if (issue_q) begin
        pc_q <= PROD_W'(cur_ay) * PROD_W'(COS_TAB[k_q]);
        ps_q <= PROD_W'(cur_ax) * PROD_W'(SIN_TAB[k_q]);
        pk_q <= k_q;
        k_q  <= k_q + 1'b1;
      end
      if (pv_q) begin
        f_q <= f_new;
        if (pk_q == ANG_LAST) begin
          k_q <= ANG_FIRST;
          f_q <= '0;
          if (!pass_q) begin
            dir_far_q <= dir_val;
          end else begin
            dir_near_q <= dir_val;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      max_radius_q <= smax_q.root;
      min_radius_q <= smin_q.root;
      max_dir_q    <= dir_far_q;
      min_dir_q    <= dir_near_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign max_radius_o    = max_radius_q;
  assign min_radius_o    = min_radius_q;
  assign max_direction_o = max_dir_q;
  assign min_direction_o = min_dir_q;

  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != B_RUN) |-> (!issue_q && !pv_q))
    else $error("angle scan active outside of a run");

  a_done_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DONE) |-> (sqrt_done && dir_done_q))
    else $error("result finished before both units");

endmodule
